[src/dssm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and sizes for the two-stack shared store: operation and
// status codes, the input and result beats, and the controller command group.
// ----------------------------------------------------------------------------
package dssm_pkg;

    // store size and derived widths
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH_A = 2'd0,
        OP_PUSH_B = 2'd1,
        OP_POP_A  = 2'd2,
        OP_POP_B  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        t_op                      operation;
        logic signed [WORD_W-1:0] push_value;
    } t_item;

    // result beat
    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] top_a;
        logic signed [WORD_W-1:0] top_b;
        logic [COUNT_W-1:0]       count_a;
        logic [COUNT_W-1:0]       count_b;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic settle;
    } t_cmd;

    // low bits of a fill count, zero-extended when the count is narrow
    function automatic logic [COUNT_W-1:0] to_count(input logic [FILL_W-1:0] fill);
        logic [FILL_W+COUNT_W-1:0] ext;
        begin
            ext      = {{COUNT_W{1'b0}}, fill};
            to_count = ext[COUNT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/dssm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_ctrl
// Sequencer for one operation: capture, execute (update counts, write or
// issue the read of the new top), settle (take the read word), respond.
// ----------------------------------------------------------------------------
module dssm_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    output logic              o_strobe,
    output dssm_pkg::t_cmd    o_cmd
);
    import dssm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state  <= S_RESP;
                    r_strobe <= 1'b1;
                end
                S_RESP: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b0;
                    r_busy   <= 1'b0;
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b0;
                    r_busy   <= 1'b0;
                end
            endcase
        end
    end

    // commands to the datapath
    assign o_cmd.capture = i_start && !r_busy;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_cmd.settle  = (r_state == S_LOAD);

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

[src/dssm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dssm_datapath
// Shared word store, fill counts and cached top words of both stacks.
// Stack A fills upward from entry 0, stack B downward from the last entry.
// ----------------------------------------------------------------------------
module dssm_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dssm_pkg::t_cmd  i_cmd,
    input  wire dssm_pkg::t_item i_item,
    output dssm_pkg::t_result    o_result
);
    import dssm_pkg::*;

    localparam logic [FILL_W:0] DEPTH_X = (FILL_W+1)'(DEPTH);

    // captured beat
    t_op                      r_op;
    logic signed [WORD_W-1:0] r_value;

    // stack state
    logic [FILL_W-1:0]        r_fill_a;
    logic [FILL_W-1:0]        r_fill_b;
    logic signed [WORD_W-1:0] r_top_a;
    logic signed [WORD_W-1:0] r_top_b;
    t_status                  r_status;
    logic                     r_reload_a;
    logic                     r_reload_b;

    // store and its registered read port
    logic [WORD_W-1:0]        mem_store [DEPTH];
    logic [WORD_W-1:0]        r_rd_data;

    logic                     full;
    logic                     empty_a;
    logic                     empty_b;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [FILL_W:0]          addr_x;
    logic [FILL_W:0]          sum_x;

    // occupancy checks
    assign sum_x   = {1'b0, r_fill_a} + {1'b0, r_fill_b};
    assign full    = (sum_x >= DEPTH_X);
    assign empty_a = (r_fill_a == '0);
    assign empty_b = (r_fill_b == '0);

    // store addressing for the operation in hand
    always_comb begin
        wr_en  = 1'b0;
        addr_x = '0;
        unique case (r_op)
            OP_PUSH_A: begin
                wr_en  = i_cmd.execute && !full;
                addr_x = {1'b0, r_fill_a};
            end
            OP_PUSH_B: begin
                wr_en  = i_cmd.execute && !full;
                addr_x = DEPTH_X - (FILL_W+1)'(1) - {1'b0, r_fill_b};
            end
            OP_POP_A: begin
                // entry just below the current top
                addr_x = {1'b0, r_fill_a} - (FILL_W+1)'(2);
            end
            OP_POP_B: begin
                addr_x = DEPTH_X - {1'b0, r_fill_b} + (FILL_W+1)'(1);
            end
            default: begin
                addr_x = '0;
            end
        endcase
    end

    assign wr_addr = addr_x[ADDR_W-1:0];
    assign rd_addr = addr_x[ADDR_W-1:0];

    // word store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_store[wr_addr] <= r_value;
        end
        r_rd_data <= mem_store[rd_addr];
    end

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_item.operation;
            r_value <= i_item.push_value;
        end
    end

    // counts, status and top words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_a   <= '0;
            r_fill_b   <= '0;
            r_top_a    <= '0;
            r_top_b    <= '0;
            r_status   <= ST_DONE;
            r_reload_a <= 1'b0;
            r_reload_b <= 1'b0;
        end else if (i_cmd.execute) begin
            r_status   <= ST_DONE;
            r_reload_a <= 1'b0;
            r_reload_b <= 1'b0;
            unique case (r_op)
                OP_PUSH_A: begin
                    if (full) begin
                        r_status <= ST_OVERFLOW;
                    end else begin
                        r_fill_a <= r_fill_a + FILL_W'(1);
                        r_top_a  <= r_value;
                    end
                end
                OP_PUSH_B: begin
                    if (full) begin
                        r_status <= ST_OVERFLOW;
                    end else begin
                        r_fill_b <= r_fill_b + FILL_W'(1);
                        r_top_b  <= r_value;
                    end
                end
                OP_POP_A: begin
                    if (empty_a) begin
                        r_status <= ST_UNDERFLOW;
                    end else begin
                        r_fill_a   <= r_fill_a - FILL_W'(1);
                        r_reload_a <= 1'b1;
                    end
                end
                OP_POP_B: begin
                    if (empty_b) begin
                        r_status <= ST_UNDERFLOW;
                    end else begin
                        r_fill_b   <= r_fill_b - FILL_W'(1);
                        r_reload_b <= 1'b1;
                    end
                end
                default: begin
                    r_status <= ST_DONE;
                end
            endcase
        end else if (i_cmd.settle) begin
            // new top after a pop, zero once the stack has emptied
            if (r_reload_a) begin
                r_top_a <= empty_a ? '0 : $signed(r_rd_data);
            end
            if (r_reload_b) begin
                r_top_b <= empty_b ? '0 : $signed(r_rd_data);
            end
            r_reload_a <= 1'b0;
            r_reload_b <= 1'b0;
        end
    end

    // result beat
    assign o_result.status  = r_status;
    assign o_result.top_a   = r_top_a;
    assign o_result.top_b   = r_top_b;
    assign o_result.count_a = to_count(r_fill_a);
    assign o_result.count_b = to_count(r_fill_b);

endmodule
`default_nettype wire

[src/dual_stack_shared_memory_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_unit
// Two stacks in one word store: A grows from the bottom, B from the top.
// Each beat pushes or pops one stack and returns status, both counts and
// both top words.
//
//   channel   handshake          payload
//   input     start / busy       i_item   (operation, push_value)
//   result    o_strobe           o_result (status, top_a, top_b, count_a, count_b)
//
// An accepted beat runs through the execute, load and respond states before the
// next one can be accepted; its result shows in the respond state, for one cycle.
// The load state is there for the store's registered read port, which fetches the
// new top word after a pop.
// busy is high from acceptance to the end of the result cycle.
// Synchronous active-low reset empties both stacks; no clearing pass.
// The receiver cannot stall: each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dssm_pkg::t_item   i_item,
    output logic                   o_strobe,
    output dssm_pkg::t_result      o_result
);
    import dssm_pkg::*;

    t_cmd cmd;

    // sequencer
    dssm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // store, counts and tops
    dssm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
